>>> rtl/dcsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcsa_pkg;

    // data widths
    localparam int SAMPLE_BITS = 10;
    localparam int COUNT_BITS  = 16;
    localparam int FRAC_BITS   = 8;
    localparam int SUM_BITS    = SAMPLE_BITS + COUNT_BITS + 1;
    localparam int AVG_BITS    = SAMPLE_BITS + FRAC_BITS + 1;
    localparam int DIV_BITS    = SUM_BITS + FRAC_BITS;
    localparam int STEP_BITS   = $clog2(DIV_BITS);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    // opcodes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_CLEAR  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic acc;
        logic clr;
        logic load;
        logic step;
    } dcsa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
    } dcsa_sts_t;

endpackage

`default_nettype wire

>>> rtl/dual_channel_signed_sample_averager_unit.sv
// channel | handshake            | payload
// --------+----------------------+---------------------------------------------
// in      | in_valid / in_stall  | opcode, sample, dir_left, dir_right
// out     | out_valid / out_stall| avg_left, avg_right, left_empty, right_empty
//
// sample and clear need no divide; a new one can follow every cycle unless stalled
// read loads the dividers and runs a bit-serial restoring divide (one quotient
// bit per cycle for both channels); the result then waits for the output transfer
// input is stalled during the divide and while a finished result is stalled
// reset is asynchronous, active low; it zeroes sums and counts and selects left first
`timescale 1ns / 1ps
`default_nettype none

module dual_channel_signed_sample_averager_unit (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    output logic                                         in_stall,
    input  wire logic        [1:0]                       opcode,
    input  wire logic        [dcsa_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic                                    dir_left,
    input  wire logic                                    dir_right,
    output logic                                         out_valid,
    input  wire logic                                    out_stall,
    output logic signed      [dcsa_pkg::AVG_BITS-1:0]    avg_left,
    output logic signed      [dcsa_pkg::AVG_BITS-1:0]    avg_right,
    output logic                                         left_empty,
    output logic                                         right_empty
);

    dcsa_pkg::dcsa_cmd_t cmd;
    dcsa_pkg::dcsa_sts_t sts;

    // sequencer
    dcsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

    // sums, counts and dividers
    dcsa_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .sample      (sample),
        .dir_left    (dir_left),
        .dir_right   (dir_right),
        .avg_left    (avg_left),
        .avg_right   (avg_right),
        .left_empty  (left_empty),
        .right_empty (right_empty)
    );

endmodule

`default_nettype wire

>>> rtl/dcsa_div.sv
`timescale 1ns / 1ps
`default_nettype none

module dcsa_div (
    input  wire logic                                    clk,
    input  wire logic                                    load,
    input  wire logic                                    step,
    input  wire logic signed [dcsa_pkg::SUM_BITS-1:0]    sum,
    input  wire logic        [dcsa_pkg::COUNT_BITS-1:0]  count,
    output logic signed      [dcsa_pkg::AVG_BITS-1:0]    avg,
    output logic                                         empty
);

    logic [dcsa_pkg::DIV_BITS-1:0]   shift_reg;
    logic [dcsa_pkg::COUNT_BITS-1:0] rem_reg;
    logic [dcsa_pkg::COUNT_BITS-1:0] divisor_reg;
    logic                            neg_reg;
    logic                            empty_reg;

    logic [dcsa_pkg::SUM_BITS-1:0]   mag;
    logic [dcsa_pkg::COUNT_BITS:0]   cand;
    logic [dcsa_pkg::COUNT_BITS:0]   diff;
    logic                            fits;
    logic [dcsa_pkg::AVG_BITS-1:0]   quot;

    // magnitude of the running sum
    assign mag = sum[dcsa_pkg::SUM_BITS-1] ? (~sum + 1'b1) : sum;

    // one restoring step: shift in next dividend bit, trial subtract
    assign cand = {rem_reg, shift_reg[dcsa_pkg::DIV_BITS-1]};
    assign diff = cand - {1'b0, divisor_reg};
    assign fits = ~diff[dcsa_pkg::COUNT_BITS];

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            shift_reg   <= dcsa_pkg::DIV_BITS'(mag) << dcsa_pkg::FRAC_BITS;
            rem_reg     <= '0;
            divisor_reg <= count;
            neg_reg     <= sum[dcsa_pkg::SUM_BITS-1];
            empty_reg   <= (count == '0);
        end
        else if (step)
        begin
            shift_reg <= {shift_reg[dcsa_pkg::DIV_BITS-2:0], fits};
            rem_reg   <= fits ? diff[dcsa_pkg::COUNT_BITS-1:0]
                              : cand[dcsa_pkg::COUNT_BITS-1:0];
        end
    end

    // sign and empty handling on the finished quotient
    assign quot  = shift_reg[dcsa_pkg::AVG_BITS-1:0];
    assign empty = empty_reg;

    always_comb
    begin
        if (empty_reg)
            avg = '0;
        else if (neg_reg)
            avg = signed'(~quot + 1'b1);
        else
            avg = signed'(quot);
    end

endmodule

`default_nettype wire

>>> rtl/dcsa_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module dcsa_dp (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire dcsa_pkg::dcsa_cmd_t                     cmd,
    output dcsa_pkg::dcsa_sts_t                          sts,
    input  wire logic        [dcsa_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic                                    dir_left,
    input  wire logic                                    dir_right,
    output logic signed      [dcsa_pkg::AVG_BITS-1:0]    avg_left,
    output logic signed      [dcsa_pkg::AVG_BITS-1:0]    avg_right,
    output logic                                         left_empty,
    output logic                                         right_empty
);

    logic signed [dcsa_pkg::SUM_BITS-1:0]   sum_left_reg,  sum_left_next;
    logic signed [dcsa_pkg::SUM_BITS-1:0]   sum_right_reg, sum_right_next;
    logic        [dcsa_pkg::COUNT_BITS-1:0] cnt_left_reg,  cnt_left_next;
    logic        [dcsa_pkg::COUNT_BITS-1:0] cnt_right_reg, cnt_right_next;
    logic                                   next_is_left_reg, next_is_left_next;
    logic        [dcsa_pkg::STEP_BITS-1:0]  step_reg, step_next;

    logic signed [dcsa_pkg::SUM_BITS-1:0]   smp_ext;

    assign smp_ext = signed'(dcsa_pkg::SUM_BITS'(sample));

    // accumulate, clear and channel toggle
    always_comb
    begin
        sum_left_next     = sum_left_reg;
        sum_right_next    = sum_right_reg;
        cnt_left_next     = cnt_left_reg;
        cnt_right_next    = cnt_right_reg;
        next_is_left_next = next_is_left_reg;
        if (cmd.clr)
        begin
            sum_left_next  = '0;
            sum_right_next = '0;
            cnt_left_next  = '0;
            cnt_right_next = '0;
        end
        else if (cmd.acc)
        begin
            next_is_left_next = ~next_is_left_reg;
            if (next_is_left_reg)
            begin
                if (cnt_left_reg != dcsa_pkg::COUNT_MAX)
                begin
                    sum_left_next = dir_left ? (sum_left_reg - smp_ext)
                                             : (sum_left_reg + smp_ext);
                    cnt_left_next = cnt_left_reg + 1'b1;
                end
            end
            else
            begin
                if (cnt_right_reg != dcsa_pkg::COUNT_MAX)
                begin
                    sum_right_next = dir_right ? (sum_right_reg - smp_ext)
                                               : (sum_right_reg + smp_ext);
                    cnt_right_next = cnt_right_reg + 1'b1;
                end
            end
        end
    end

    // divide step counter
    always_comb
    begin
        step_next = step_reg;
        if (cmd.load)
            step_next = dcsa_pkg::STEP_BITS'(dcsa_pkg::DIV_BITS - 1);
        else if (cmd.step)
            step_next = step_reg - 1'b1;
    end

    assign sts.div_last = (step_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_left_reg     <= '0;
            sum_right_reg    <= '0;
            cnt_left_reg     <= '0;
            cnt_right_reg    <= '0;
            next_is_left_reg <= 1'b1;
            step_reg         <= '0;
        end
        else
        begin
            sum_left_reg     <= sum_left_next;
            sum_right_reg    <= sum_right_next;
            cnt_left_reg     <= cnt_left_next;
            cnt_right_reg    <= cnt_right_next;
            next_is_left_reg <= next_is_left_next;
            step_reg         <= step_next;
        end
    end

    // one serial divider per channel, stepped together
    dcsa_div u_div_left (
        .clk   (clk),
        .load  (cmd.load),
        .step  (cmd.step),
        .sum   (sum_left_reg),
        .count (cnt_left_reg),
        .avg   (avg_left),
        .empty (left_empty)
    );

    dcsa_div u_div_right (
        .clk   (clk),
        .load  (cmd.load),
        .step  (cmd.step),
        .sum   (sum_right_reg),
        .count (cnt_right_reg),
        .avg   (avg_right),
        .empty (right_empty)
    );

endmodule

`default_nettype wire

>>> rtl/dcsa_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module dcsa_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [1:0]           opcode,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output dcsa_pkg::dcsa_cmd_t       cmd,
    input  wire dcsa_pkg::dcsa_sts_t  sts
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       take;

    // input is free unless dividing or holding a result that is stalled
    assign in_stall  = (state_reg == ST_DIV) || ((state_reg == ST_OUT) && out_stall);
    assign out_valid = (state_reg == ST_OUT);
    assign take      = in_valid && !in_stall;

    // commands and next state
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE, ST_OUT:
            begin
                if (state_reg == ST_OUT && !out_stall)
                    state_next = ST_IDLE;
                if (take)
                begin
                    unique case (opcode)
                        dcsa_pkg::OP_SAMPLE: cmd.acc = 1'b1;
                        dcsa_pkg::OP_CLEAR:  cmd.clr = 1'b1;
                        dcsa_pkg::OP_READ:
                        begin
                            cmd.load   = 1'b1;
                            state_next = ST_DIV;
                        end
                        default: ;
                    endcase
                end
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (sts.div_last)
                    state_next = ST_OUT;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

>>> rtl/dcsa_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module dcsa_checker (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    in_valid,
    input  wire logic                                    in_stall,
    input  wire logic        [1:0]                       opcode,
    input  wire logic                                    out_valid,
    input  wire logic                                    out_stall,
    input  wire logic signed [dcsa_pkg::AVG_BITS-1:0]    avg_left,
    input  wire logic signed [dcsa_pkg::AVG_BITS-1:0]    avg_right,
    input  wire logic                                    left_empty,
    input  wire logic                                    right_empty
);

    // stalled result stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // stalled result payload is stable
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(avg_left) && $stable(avg_right)
            && $stable(left_empty) && $stable(right_empty))
        else $error("result payload changed while stalled");

    // an empty channel reads as zero
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!left_empty || avg_left == '0) && (!right_empty || avg_right == '0))
        else $error("empty channel with nonzero average");

    // a read transfer starts the divide: input stalled, no result yet
    a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == dcsa_pkg::OP_READ |=> in_stall && !out_valid)
        else $error("read did not start the divide");

    // sample and clear never produce a result
    a_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && in_valid && !in_stall && opcode != dcsa_pkg::OP_READ |=> !out_valid)
        else $error("result without a read");

endmodule

bind dual_channel_signed_sample_averager_unit dcsa_checker u_dcsa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .opcode      (opcode),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .avg_left    (avg_left),
    .avg_right   (avg_right),
    .left_empty  (left_empty),
    .right_empty (right_empty)
);

`default_nettype wire
